FILE: rtl/printf_integer_formatter_unit_defines.svh
// Assertion macros shared by the formatter RTL.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef PRINTF_INTEGER_FORMATTER_UNIT_DEFINES_SVH
`define PRINTF_INTEGER_FORMATTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pif_pkg.sv
`timescale 1ns / 1ps

package pif_pkg;

  // Width of all field length and position arithmetic
  localparam int LEN_W = 8;

  // Conversion kinds
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_OCT  = 3'd2;
  localparam logic [2:0] OP_HEXL = 3'd3;
  localparam logic [2:0] OP_HEXU = 3'd4;
  localparam logic [2:0] OP_PTR  = 3'd5;
  localparam logic [2:0] OP_CHAR = 3'd6;
  localparam logic [2:0] OP_PCT  = 3'd7;

  // Operand sizes
  localparam logic [1:0] LM_INT   = 2'd0;
  localparam logic [1:0] LM_SHORT = 2'd1;

  // ASCII codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CONV = 8'b0000_0010,
    S_NORM = 8'b0000_0100,
    S_PLAN = 8'b0000_1000,
    S_SIZE = 8'b0001_0000,
    S_PAD  = 8'b0010_0000,
    S_LAY  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  // Map one digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] n8;
    n8 = {4'd0, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + n8;
    end
    return (upper ? CH_UA : CH_LA) + n8 - 8'd10;
  endfunction

endpackage

FILE: rtl/printf_integer_formatter_unit.sv
`timescale 1ns / 1ps
`include "printf_integer_formatter_unit_defines.svh"

// printf integer formatter: turns one integer, character or percent conversion
// request into the ASCII characters of the formatted field.
// Request channel: drive the request fields and pulse start; the request is
// taken on a rising edge with start high and busy low. busy stays high until
// the last character of the field has been issued.
// Result channel: each character appears for exactly one cycle with strobe
// high; last marks the final one. An empty field gives a single transfer with
// char_valid low and last high. The receiver cannot stall the block.
// Sequence from the accepting edge to the first character: the bit-serial
// conversion (a bit per step for decimal, an octal or hex digit per step
// otherwise, over MAG_W = VALUE_BITS rounded up past the next multiple of 12,
// so 72 for 64-bit values), then leading-zero removal of up to NDIG digits
// (NDIG = MAG_W/3), then the layout states PLAN, SIZE, PAD and LAY and the
// output state EMIT; character and percent skip conversion and zero removal.
// Characters then follow one per cycle, at most min(MAX_FIELD, 64).
// busy drops in the cycle that shows the last character, so the next request
// may be taken there. Reset returns the block to idle and drops strobe.
module printf_integer_formatter_unit import pif_pkg::*; #(
  parameter int MAX_FIELD  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [1:0]  length_mode,
  input  logic [63:0] operand,
  input  logic        flag_left,
  input  logic        flag_plus,
  input  logic        flag_space,
  input  logic        flag_alt,
  input  logic        flag_zero,
  input  logic [6:0]  field_width,
  input  logic        has_precision,
  input  logic [6:0]  min_digits,
  output logic        strobe,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        last
);

  localparam int MAG_W = ((VALUE_BITS + 12) / 12) * 12;
  localparam int NDIG  = MAG_W / 3;
  localparam int DIG_W = NDIG * 4;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam int ND_W  = $clog2(NDIG + 1);
  localparam int LIMIT = (MAX_FIELD < 64) ? MAX_FIELD : 64;

  state_t state;

  // Request registers
  logic [2:0]       opc;
  logic             f_left;
  logic             f_alt;
  logic             f_zp;
  logic             f_prec;
  logic [6:0]       prec;
  logic [6:0]       fw;
  logic             sign_on;
  logic [7:0]       sign_ch;
  logic [7:0]       chr;

  // Conversion shift registers
  logic [MAG_W-1:0] mag;
  logic [DIG_W-1:0] dig;
  logic [CNT_W-1:0] cnt;
  logic [ND_W-1:0]  ndig;

  // Layout registers
  logic [LEN_W-1:0] zeros;
  logic [1:0]       npre;
  logic [LEN_W-1:0] body;
  logic [LEN_W-1:0] pad;
  logic [LEN_W-1:0] b_lpad;
  logic [LEN_W-1:0] b_sign;
  logic [LEN_W-1:0] b_pre;
  logic [LEN_W-1:0] b_zeros;
  logic [LEN_W-1:0] b_dig;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] p;

  // Request decode
  logic                  size16;
  logic                  size32;
  logic                  sbit;
  logic                  neg;
  logic                  req_single;
  logic [VALUE_BITS-1:0] op_mask;
  logic [VALUE_BITS-1:0] op_v;
  logic [VALUE_BITS-1:0] op_mag;
  logic [CNT_W-1:0]      steps;

  always_comb begin
    size16     = (length_mode == LM_SHORT) && (opcode != OP_PTR);
    size32     = (length_mode == LM_INT) && (opcode != OP_PTR);
    req_single = opcode inside {OP_CHAR, OP_PCT};
    if (size16) begin
      op_mask = VALUE_BITS'(16'hFFFF);
      sbit    = operand[15];
    end else if (size32) begin
      op_mask = VALUE_BITS'(32'hFFFF_FFFF);
      sbit    = operand[31];
    end else begin
      op_mask = '1;
      sbit    = operand[VALUE_BITS-1];
    end
    op_v   = operand[VALUE_BITS-1:0] & op_mask;
    neg    = (opcode == OP_SDEC) && sbit;
    op_mag = neg ? ((~op_v + VALUE_BITS'(1)) & op_mask) : op_v;
    case (opcode)
      OP_SDEC, OP_UDEC: steps = CNT_W'(MAG_W);
      OP_OCT:           steps = CNT_W'(MAG_W / 3);
      default:          steps = CNT_W'(MAG_W / 4);
    endcase
  end

  // One conversion step: a bit for decimal, an octal or hex digit otherwise
  logic [DIG_W-1:0] dd;
  logic [DIG_W-1:0] dig_next;
  logic [MAG_W-1:0] mag_next;

  always_comb begin
    dd = dig;
    for (int i = 0; i < NDIG; i++) begin
      if (dig[i*4 +: 4] >= 4'd5) begin
        dd[i*4 +: 4] = dig[i*4 +: 4] + 4'd3;
      end
    end
    case (opc)
      OP_SDEC, OP_UDEC: begin
        dig_next = {dd[DIG_W-2:0], mag[MAG_W-1]};
        mag_next = {mag[MAG_W-2:0], 1'b0};
      end
      OP_OCT: begin
        dig_next = {dig[DIG_W-5:0], 1'b0, mag[MAG_W-1 -: 3]};
        mag_next = {mag[MAG_W-4:0], 3'd0};
      end
      default: begin
        dig_next = {dig[DIG_W-5:0], mag[MAG_W-1 -: 4]};
        mag_next = {mag[MAG_W-5:0], 4'd0};
      end
    endcase
  end

  // Precision zeros and prefix length
  logic [LEN_W-1:0] mind;
  logic [LEN_W-1:0] ndig_l;
  logic [LEN_W-1:0] zeros_next;
  logic [1:0]       npre_next;
  logic             single;

  always_comb begin
    single = opc inside {OP_CHAR, OP_PCT};
    mind   = f_prec ? LEN_W'(prec) : LEN_W'(1);
    ndig_l = LEN_W'(ndig);
    zeros_next = (mind > ndig_l) ? (mind - ndig_l) : '0;
    if ((opc == OP_OCT) && f_alt && (zeros_next == '0)) begin
      zeros_next = LEN_W'(1);
    end
    if (single) begin
      zeros_next = '0;
    end
    if (opc == OP_PTR) begin
      npre_next = 2'd2;
    end else if ((opc == OP_HEXL || opc == OP_HEXU) && f_alt && (ndig != '0)) begin
      npre_next = 2'd2;
    end else begin
      npre_next = 2'd0;
    end
  end

  // Layout boundaries
  logic [LEN_W-1:0] lead;
  logic [LEN_W-1:0] zpad;

  always_comb begin
    lead = (!f_left && !f_zp) ? pad : '0;
    zpad = f_zp ? pad : '0;
  end

  // Character at the current position
  logic [7:0] emit_ch;
  logic       emit_dig;
  logic       emit_last;

  always_comb begin
    emit_dig = 1'b0;
    if (p < b_lpad) begin
      emit_ch = CH_SPACE;
    end else if (p < b_sign) begin
      emit_ch = sign_ch;
    end else if (p < b_pre) begin
      emit_ch = (p == b_sign) ? CH_ZERO : ((opc == OP_HEXU) ? CH_UX : CH_LX);
    end else if (p < b_zeros) begin
      emit_ch = CH_ZERO;
    end else if (p < b_dig) begin
      emit_ch  = single ? chr : digit_char(dig[DIG_W-1 -: 4], opc == OP_HEXU);
      emit_dig = 1'b1;
    end else begin
      emit_ch = CH_SPACE;
    end
    emit_last = ((p + LEN_W'(1)) == len) || ((p + LEN_W'(1)) == LEN_W'(LIMIT));
  end

  assign busy = (state != S_IDLE);

  // Control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= req_single ? S_PLAN : S_CONV;
          end
        end
        S_CONV: begin
          if (cnt == CNT_W'(1)) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (!((ndig != '0) && (dig[DIG_W-1 -: 4] == 4'd0))) begin
            state <= S_PLAN;
          end
        end
        S_PLAN: state <= S_SIZE;
        S_SIZE: state <= S_PAD;
        S_PAD:  state <= S_LAY;
        S_LAY:  state <= S_EMIT;
        S_EMIT: begin
          strobe <= 1'b1;
          if ((len == '0) || emit_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        // Hold the request and load the magnitude
        opc     <= opcode;
        f_left  <= flag_left;
        f_alt   <= flag_alt;
        f_zp    <= flag_zero && !flag_left && !has_precision && !req_single;
        f_prec  <= has_precision;
        prec    <= min_digits;
        fw      <= field_width;
        sign_on <= (opcode == OP_SDEC) && (neg || flag_plus || flag_space);
        sign_ch <= neg ? CH_MINUS : (flag_plus ? CH_PLUS : CH_SPACE);
        chr     <= (opcode == OP_CHAR) ? operand[7:0] : CH_PCT;
        mag     <= {{(MAG_W - VALUE_BITS){1'b0}}, op_mag};
        dig     <= '0;
        cnt     <= steps;
        ndig    <= ND_W'(1);
      end
      S_CONV: begin
        dig <= dig_next;
        mag <= mag_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          ndig <= ND_W'(NDIG);
        end
      end
      S_NORM: begin
        // Drop leading zero digits
        if ((ndig != '0) && (dig[DIG_W-1 -: 4] == 4'd0)) begin
          dig  <= {dig[DIG_W-5:0], 4'd0};
          ndig <= ndig - ND_W'(1);
        end
      end
      S_PLAN: begin
        zeros <= zeros_next;
        npre  <= npre_next;
      end
      S_SIZE: begin
        body <= LEN_W'(sign_on) + LEN_W'(npre) + zeros + LEN_W'(ndig);
      end
      S_PAD: begin
        pad <= (LEN_W'(fw) > body) ? (LEN_W'(fw) - body) : '0;
      end
      S_LAY: begin
        b_lpad  <= lead;
        b_sign  <= lead + LEN_W'(sign_on);
        b_pre   <= lead + LEN_W'(sign_on) + LEN_W'(npre);
        b_zeros <= lead + zpad + LEN_W'(sign_on) + LEN_W'(npre) + zeros;
        b_dig   <= lead + zpad + body;
        len     <= body + pad;
        p       <= '0;
      end
      S_EMIT: begin
        // Issue one character and advance
        if (len == '0) begin
          out_char   <= CH_NUL;
          char_valid <= 1'b0;
          last       <= 1'b1;
        end else begin
          out_char   <= emit_ch;
          char_valid <= 1'b1;
          last       <= emit_last;
          p          <= p + LEN_W'(1);
          if (emit_dig) begin
            dig <= {dig[DIG_W-5:0], 4'd0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  `PIF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
  `PIF_ASSERT_IMP(a_last_idle, strobe && last, !busy, "still busy after last transfer")
  `PIF_ASSERT_IMP(a_empty_last, strobe && !char_valid, last, "empty marker without last")
  `PIF_ASSERT_IMP(a_emit_limit, state == S_EMIT, p < LEN_W'(LIMIT), "field ran past limit")

endmodule
